/* hw/rtl/dpsu_pkg.sv */
package dpsu_pkg;

  // register map, index = paddr[4:2]
  localparam logic [2:0] REG_INV_FX   = 3'd0;
  localparam logic [2:0] REG_INV_FY   = 3'd1;
  localparam logic [2:0] REG_CEN_X    = 3'd2;
  localparam logic [2:0] REG_CEN_Y    = 3'd3;
  localparam logic [2:0] REG_EDGE_THR = 3'd4;
  localparam logic [2:0] REG_FIX_COL  = 3'd5;
  localparam logic [2:0] REG_ALPHA    = 3'd6;
  localparam logic [2:0] REG_COL_EN   = 3'd7;

  localparam logic [23:0] INV_FX_RST   = 24'd31957;
  localparam logic [23:0] INV_FY_RST   = 24'd31957;
  localparam logic [13:0] CEN_X_RST    = 14'd5112;
  localparam logic [13:0] CEN_Y_RST    = 14'd3832;
  localparam logic [9:0]  EDGE_THR_RST = 10'd20;
  localparam logic [23:0] FIX_COL_RST  = 24'hFFFFFF;
  localparam logic [7:0]  ALPHA_RST    = 8'd77;

  // 0.2588 in Q1.14, 1.2/sqrt(2) in Q0.16, 1.0 in Q1.14
  localparam logic [14:0] NZ_FLOOR = 15'd4240;
  localparam logic [15:0] RADIUS_K = 16'd55609;
  localparam logic [14:0] N_ONE    = 15'd16384;

  // number of significant bits
  function automatic logic [6:0] msb_len(input logic [63:0] v);
    logic [6:0] n;
    n = 7'd0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) n = 7'(i + 1);
    end
    return n;
  endfunction

  // exact x/255 for x below 65280
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + 17'(x[15:8]) + 17'd1;
    return s[15:8];
  endfunction

endpackage

/* hw/rtl/depth_pixel_to_surfel_unit.sv */
// path to out_strobe: stages A-M, square root, N, normal divider, O, radius divider
// throughput: one pixel per clock; the 31-step square root and the two
// bit-per-stage dividers (15 and 26 steps) set the depth, not the rate
// busy is never raised and the receiver cannot stall, so the pipeline never holds
// reset (synchronous, rst_n low) clears all valid bits and loads register defaults
module depth_pixel_to_surfel_unit #(
  parameter int FRAME_ROWS = 480,
  parameter int FRAME_COLS = 640
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [9:0]         in_pixel_row,
  input  logic [9:0]         in_pixel_col,
  input  logic [15:0]        in_depth_centre,
  input  logic [15:0]        in_depth_left,
  input  logic [15:0]        in_depth_right,
  input  logic [15:0]        in_depth_above,
  input  logic [15:0]        in_depth_below,
  input  logic [7:0]         in_image_red,
  input  logic [7:0]         in_image_green,
  input  logic [7:0]         in_image_blue,
  output logic               out_strobe,
  output logic signed [31:0] out_point_x,
  output logic signed [31:0] out_point_y,
  output logic [23:0]        out_point_z,
  output logic signed [15:0] out_normal_x,
  output logic signed [15:0] out_normal_y,
  output logic signed [15:0] out_normal_z,
  output logic [31:0]        out_splat_radius,
  output logic [7:0]         out_colour_red,
  output logic [7:0]         out_colour_green,
  output logic [7:0]         out_colour_blue,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic [23:0]        pz;
    logic [23:0]        col;
    logic [55:0]        num;
    logic               border;
  } info_t;

  typedef struct packed {
    logic [2:0][29:0] mag;
    logic [2:0]       sgn;
    logic             zero;
    info_t            info;
  } sq_side_t;

  typedef struct packed {
    logic [2:0] sgn;
    logic       zero;
    info_t      info;
  } dv_side_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic [23:0]        pz;
    logic [23:0]        col;
    logic [2:0][15:0]   nrm;
  } rd_side_t;

  // ---------------- configuration ----------------
  logic [23:0] inv_fx_r, inv_fy_r, fcol_r;
  logic [13:0] cen_x_r, cen_y_r;
  logic [9:0]  thr_r;
  logic [7:0]  alpha_r;
  logic        col_en_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_fx_r <= dpsu_pkg::INV_FX_RST;
      inv_fy_r <= dpsu_pkg::INV_FY_RST;
      cen_x_r  <= dpsu_pkg::CEN_X_RST;
      cen_y_r  <= dpsu_pkg::CEN_Y_RST;
      thr_r    <= dpsu_pkg::EDGE_THR_RST;
      fcol_r   <= dpsu_pkg::FIX_COL_RST;
      alpha_r  <= dpsu_pkg::ALPHA_RST;
      col_en_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        dpsu_pkg::REG_INV_FX:   inv_fx_r <= pwdata[23:0];
        dpsu_pkg::REG_INV_FY:   inv_fy_r <= pwdata[23:0];
        dpsu_pkg::REG_CEN_X:    cen_x_r  <= pwdata[13:0];
        dpsu_pkg::REG_CEN_Y:    cen_y_r  <= pwdata[13:0];
        dpsu_pkg::REG_EDGE_THR: thr_r    <= pwdata[9:0];
        dpsu_pkg::REG_FIX_COL:  fcol_r   <= pwdata[23:0];
        dpsu_pkg::REG_ALPHA:    alpha_r  <= pwdata[7:0];
        dpsu_pkg::REG_COL_EN:   col_en_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      dpsu_pkg::REG_INV_FX:   prdata = {8'd0, inv_fx_r};
      dpsu_pkg::REG_INV_FY:   prdata = {8'd0, inv_fy_r};
      dpsu_pkg::REG_CEN_X:    prdata = {18'd0, cen_x_r};
      dpsu_pkg::REG_CEN_Y:    prdata = {18'd0, cen_y_r};
      dpsu_pkg::REG_EDGE_THR: prdata = {22'd0, thr_r};
      dpsu_pkg::REG_FIX_COL:  prdata = {8'd0, fcol_r};
      dpsu_pkg::REG_ALPHA:    prdata = {24'd0, alpha_r};
      dpsu_pkg::REG_COL_EN:   prdata = {31'd0, col_en_r};
      default:                prdata = '0;
    endcase
  end

  // ---------------- helpers ----------------
  function automatic logic near_f(input logic [15:0] dc, input logic [15:0] dn,
                                  input logic [9:0] thr);
    logic [15:0] diff;
    diff = (dc > dn) ? dc - dn : dn - dc;
    return diff < {6'd0, thr};
  endfunction

  function automatic logic signed [37:0] rnd20(input logic signed [56:0] q);
    logic [56:0] m;
    logic [36:0] r;
    m = q[56] ? 57'(-q) : 57'(q);
    r = 37'((m + 57'd524288) >> 20);
    return q[56] ? -$signed({1'b0, r}) : $signed({1'b0, r});
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
    if (v > 38'sd2147483647) return 32'h7FFF_FFFF;
    else if (v < -38'sd2147483648) return 32'h8000_0000;
    else return v[31:0];
  endfunction

  function automatic logic signed [38:0] tsel(input logic okm, input logic okp,
                                              input logic signed [38:0] o,
                                              input logic signed [38:0] m,
                                              input logic signed [38:0] p,
                                              input logic unit);
    if (okm && okp) return p - m;
    else if (okp) return p - o;
    else if (okm) return o - m;
    else return unit ? 39'sd256 : 39'sd0;
  endfunction

  // ---------------- stage A: capture, offsets, neighbour tests ----------------
  logic               accept;
  logic signed [15:0] offx_c, offy_c;

  assign busy   = 1'b0;
  assign accept = start & ~busy;
  assign offx_c = $signed({2'b00, in_pixel_col, 4'b0000}) - $signed({2'b00, cen_x_r});
  assign offy_c = $signed({2'b00, in_pixel_row, 4'b0000}) - $signed({2'b00, cen_y_r});

  logic               a_vld_r, a_border_r;
  logic [15:0]        a_dep_r [5];   // centre, left, right, above, below
  logic signed [15:0] a_offx_r [3];  // minus, centre, plus
  logic signed [15:0] a_offy_r [3];
  logic [3:0]         a_near_r;      // left, right, above, below
  logic [7:0]         a_img_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) a_vld_r <= 1'b0;
    else a_vld_r <= accept;
  end

  always_ff @(posedge clk) begin
    a_dep_r[0]  <= in_depth_centre;
    a_dep_r[1]  <= in_depth_left;
    a_dep_r[2]  <= in_depth_right;
    a_dep_r[3]  <= in_depth_above;
    a_dep_r[4]  <= in_depth_below;
    a_offx_r[0] <= offx_c - 16'sd16;
    a_offx_r[1] <= offx_c;
    a_offx_r[2] <= offx_c + 16'sd16;
    a_offy_r[0] <= offy_c - 16'sd16;
    a_offy_r[1] <= offy_c;
    a_offy_r[2] <= offy_c + 16'sd16;
    a_near_r[0] <= near_f(in_depth_centre, in_depth_left, thr_r);
    a_near_r[1] <= near_f(in_depth_centre, in_depth_right, thr_r);
    a_near_r[2] <= near_f(in_depth_centre, in_depth_above, thr_r);
    a_near_r[3] <= near_f(in_depth_centre, in_depth_below, thr_r);
    a_border_r  <= (in_pixel_row == 10'd0) || (in_pixel_col == 10'd0) ||
                   (in_pixel_row >= 10'(FRAME_ROWS - 1)) ||
                   (in_pixel_col >= 10'(FRAME_COLS - 1));
    a_img_r[0]  <= in_image_red;
    a_img_r[1]  <= in_image_green;
    a_img_r[2]  <= in_image_blue;
  end

  // ---------------- stage B: depth times offset ----------------
  logic               b_vld_r, b_border_r;
  logic signed [32:0] b_px_r [5];
  logic signed [32:0] b_py_r [5];
  logic [15:0]        b_dep_r [5];
  logic [3:0]         b_near_r;
  logic [39:0]        b_dinv_r;
  logic [15:0]        b_cf_r [3];
  logic [15:0]        b_ci_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) b_vld_r <= 1'b0;
    else b_vld_r <= a_vld_r;
  end

  always_ff @(posedge clk) begin
    b_px_r[0] <= $signed({1'b0, a_dep_r[0]}) * a_offx_r[1];
    b_px_r[1] <= $signed({1'b0, a_dep_r[1]}) * a_offx_r[0];
    b_px_r[2] <= $signed({1'b0, a_dep_r[2]}) * a_offx_r[2];
    b_px_r[3] <= $signed({1'b0, a_dep_r[3]}) * a_offx_r[1];
    b_px_r[4] <= $signed({1'b0, a_dep_r[4]}) * a_offx_r[1];
    b_py_r[0] <= $signed({1'b0, a_dep_r[0]}) * a_offy_r[1];
    b_py_r[1] <= $signed({1'b0, a_dep_r[1]}) * a_offy_r[1];
    b_py_r[2] <= $signed({1'b0, a_dep_r[2]}) * a_offy_r[1];
    b_py_r[3] <= $signed({1'b0, a_dep_r[3]}) * a_offy_r[0];
    b_py_r[4] <= $signed({1'b0, a_dep_r[4]}) * a_offy_r[2];
    b_dinv_r  <= a_dep_r[0] * inv_fx_r;
    b_dep_r   <= a_dep_r;
    b_near_r  <= a_near_r;
    b_border_r <= a_border_r;
    for (int ch = 0; ch < 3; ch++) begin
      b_cf_r[ch] <= alpha_r * fcol_r[23-8*ch -: 8];
      b_ci_r[ch] <= (8'd255 - alpha_r) * a_img_r[ch];
    end
  end

  // ---------------- stage C: times reciprocal focal length ----------------
  logic               c_vld_r, c_border_r;
  logic signed [56:0] c_qx_r [5];
  logic signed [56:0] c_qy_r [5];
  logic [15:0]        c_dep_r [5];
  logic [3:0]         c_near_r;
  logic [55:0]        c_num_r;
  logic [23:0]        c_col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) c_vld_r <= 1'b0;
    else c_vld_r <= b_vld_r;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 5; k++) begin
      c_qx_r[k] <= b_px_r[k] * $signed({1'b0, inv_fx_r});
      c_qy_r[k] <= b_py_r[k] * $signed({1'b0, inv_fy_r});
    end
    c_num_r    <= b_dinv_r * dpsu_pkg::RADIUS_K;
    c_dep_r    <= b_dep_r;
    c_near_r   <= b_near_r;
    c_border_r <= b_border_r;
    for (int ch = 0; ch < 3; ch++) begin
      c_col_r[23-8*ch -: 8] <= col_en_r ?
          dpsu_pkg::div255(b_cf_r[ch] + b_ci_r[ch] + 16'd127) : fcol_r[23-8*ch -: 8];
    end
  end

  // ---------------- stage D: rounding to Q.8 ----------------
  logic               d_vld_r, d_border_r;
  logic signed [37:0] d_x_r [5];
  logic signed [37:0] d_y_r [5];
  logic [15:0]        d_dep_r [5];
  logic [3:0]         d_near_r;
  logic [55:0]        d_num_r;
  logic [23:0]        d_col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) d_vld_r <= 1'b0;
    else d_vld_r <= c_vld_r;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 5; k++) begin
      d_x_r[k] <= rnd20(c_qx_r[k]);
      d_y_r[k] <= rnd20(c_qy_r[k]);
    end
    d_dep_r    <= c_dep_r;
    d_near_r   <= c_near_r;
    d_num_r    <= c_num_r;
    d_col_r    <= c_col_r;
    d_border_r <= c_border_r;
  end

  // ---------------- stage E: tangents ----------------
  logic signed [38:0] px39 [5];
  logic signed [38:0] py39 [5];
  logic signed [38:0] pz39 [5];

  always_comb begin
    for (int k = 0; k < 5; k++) begin
      px39[k] = 39'(d_x_r[k]);
      py39[k] = 39'(d_y_r[k]);
      pz39[k] = $signed({15'd0, d_dep_r[k], 8'd0});
    end
  end

  logic               e_vld_r;
  logic signed [38:0] e_th_r [3];
  logic signed [38:0] e_tv_r [3];
  info_t              e_info_r;

  always_ff @(posedge clk) begin
    if (!rst_n) e_vld_r <= 1'b0;
    else e_vld_r <= d_vld_r;
  end

  always_ff @(posedge clk) begin
    e_th_r[0] <= tsel(d_near_r[0], d_near_r[1], px39[0], px39[1], px39[2], 1'b1);
    e_th_r[1] <= tsel(d_near_r[0], d_near_r[1], py39[0], py39[1], py39[2], 1'b0);
    e_th_r[2] <= tsel(d_near_r[0], d_near_r[1], pz39[0], pz39[1], pz39[2], 1'b0);
    e_tv_r[0] <= tsel(d_near_r[2], d_near_r[3], px39[0], px39[3], px39[4], 1'b0);
    e_tv_r[1] <= tsel(d_near_r[2], d_near_r[3], py39[0], py39[3], py39[4], 1'b1);
    e_tv_r[2] <= tsel(d_near_r[2], d_near_r[3], pz39[0], pz39[3], pz39[4], 1'b0);
    e_info_r.px     <= sat32(d_x_r[0]);
    e_info_r.py     <= sat32(d_y_r[0]);
    e_info_r.pz     <= {d_dep_r[0], 8'd0};
    e_info_r.col    <= d_col_r;
    e_info_r.num    <= d_num_r;
    e_info_r.border <= d_border_r;
  end

  // ---------------- stage F: tangent magnitudes ----------------
  logic        f_vld_r;
  logic [38:0] f_mh_r [3];
  logic [38:0] f_mv_r [3];
  logic [2:0]  f_sh_r, f_sv_r;
  logic [38:0] f_orh_r, f_orv_r;
  info_t       f_info_r;
  logic [38:0] mh [3];
  logic [38:0] mv [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mh[i] = e_th_r[i][38] ? 39'(-e_th_r[i]) : 39'(e_th_r[i]);
      mv[i] = e_tv_r[i][38] ? 39'(-e_tv_r[i]) : 39'(e_tv_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) f_vld_r <= 1'b0;
    else f_vld_r <= e_vld_r;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      f_mh_r[i] <= mh[i];
      f_mv_r[i] <= mv[i];
      f_sh_r[i] <= e_th_r[i][38];
      f_sv_r[i] <= e_tv_r[i][38];
    end
    // the OR of magnitudes has the same bit length as their maximum
    f_orh_r  <= mh[0] | mh[1] | mh[2];
    f_orv_r  <= mv[0] | mv[1] | mv[2];
    f_info_r <= e_info_r;
  end

  // ---------------- stage G: shrink tangents below 2^20 ----------------
  logic [6:0]  blh, blv, shh, shv;
  logic [38:0] gmh [3];
  logic [38:0] gmv [3];

  always_comb begin
    blh = dpsu_pkg::msb_len({25'd0, f_orh_r});
    blv = dpsu_pkg::msb_len({25'd0, f_orv_r});
    shh = (blh > 7'd20) ? blh - 7'd20 : 7'd0;
    shv = (blv > 7'd20) ? blv - 7'd20 : 7'd0;
    for (int i = 0; i < 3; i++) begin
      gmh[i] = f_mh_r[i] >> shh;
      gmv[i] = f_mv_r[i] >> shv;
    end
  end

  logic               g_vld_r;
  logic signed [20:0] g_th_r [3];
  logic signed [20:0] g_tv_r [3];
  info_t              g_info_r;

  always_ff @(posedge clk) begin
    if (!rst_n) g_vld_r <= 1'b0;
    else g_vld_r <= f_vld_r;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      g_th_r[i] <= f_sh_r[i] ? -$signed({1'b0, gmh[i][19:0]}) : $signed({1'b0, gmh[i][19:0]});
      g_tv_r[i] <= f_sv_r[i] ? -$signed({1'b0, gmv[i][19:0]}) : $signed({1'b0, gmv[i][19:0]});
    end
    g_info_r <= f_info_r;
  end

  // ---------------- stage H/I: cross product vertical x horizontal ----------------
  logic               h_vld_r;
  logic signed [41:0] h_p_r [6];
  info_t              h_info_r;

  always_ff @(posedge clk) begin
    if (!rst_n) h_vld_r <= 1'b0;
    else h_vld_r <= g_vld_r;
  end

  always_ff @(posedge clk) begin
    h_p_r[0] <= g_tv_r[1] * g_th_r[2];
    h_p_r[1] <= g_tv_r[2] * g_th_r[1];
    h_p_r[2] <= g_tv_r[2] * g_th_r[0];
    h_p_r[3] <= g_tv_r[0] * g_th_r[2];
    h_p_r[4] <= g_tv_r[0] * g_th_r[1];
    h_p_r[5] <= g_tv_r[1] * g_th_r[0];
    h_info_r <= g_info_r;
  end

  logic               i_vld_r;
  logic signed [42:0] i_c_r [3];
  info_t              i_info_r;

  always_ff @(posedge clk) begin
    if (!rst_n) i_vld_r <= 1'b0;
    else i_vld_r <= h_vld_r;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      i_c_r[i] <= 43'(h_p_r[2*i]) - 43'(h_p_r[2*i+1]);
    end
    i_info_r <= h_info_r;
  end

  // ---------------- stage J/K: normalise largest component to [2^29, 2^30) ----------------
  logic        j_vld_r;
  logic [41:0] j_m_r [3];
  logic [2:0]  j_s_r;
  logic [41:0] j_or_r;
  info_t       j_info_r;
  logic [42:0] cm [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cm[i] = i_c_r[i][42] ? 43'(-i_c_r[i]) : 43'(i_c_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) j_vld_r <= 1'b0;
    else j_vld_r <= i_vld_r;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      j_m_r[i] <= cm[i][41:0];
      j_s_r[i] <= i_c_r[i][42];
    end
    j_or_r   <= cm[0][41:0] | cm[1][41:0] | cm[2][41:0];
    j_info_r <= i_info_r;
  end

  logic [6:0]  blc;
  logic [41:0] nm [3];

  always_comb begin
    blc = dpsu_pkg::msb_len({22'd0, j_or_r});
    for (int i = 0; i < 3; i++) begin
      if (blc >= 7'd30) nm[i] = j_m_r[i] >> (blc - 7'd30);
      else nm[i] = j_m_r[i] << (7'd30 - blc);
    end
  end

  logic        k_vld_r, k_zero_r;
  logic [29:0] k_mag_r [3];
  logic [2:0]  k_s_r;
  info_t       k_info_r;

  always_ff @(posedge clk) begin
    if (!rst_n) k_vld_r <= 1'b0;
    else k_vld_r <= j_vld_r;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) k_mag_r[i] <= nm[i][29:0];
    k_s_r    <= j_s_r;
    k_zero_r <= (blc == 7'd0);
    k_info_r <= j_info_r;
  end

  // ---------------- stage L/M: sum of squares ----------------
  logic        l_vld_r, l_zero_r;
  logic [59:0] l_sq_r [3];
  logic [29:0] l_mag_r [3];
  logic [2:0]  l_s_r;
  info_t       l_info_r;

  always_ff @(posedge clk) begin
    if (!rst_n) l_vld_r <= 1'b0;
    else l_vld_r <= k_vld_r;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) l_sq_r[i] <= k_mag_r[i] * k_mag_r[i];
    l_mag_r  <= k_mag_r;
    l_s_r    <= k_s_r;
    l_zero_r <= k_zero_r;
    l_info_r <= k_info_r;
  end

  logic        m_vld_r;
  logic [61:0] m_ss_r;
  sq_side_t    m_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) m_vld_r <= 1'b0;
    else m_vld_r <= l_vld_r;
  end

  always_ff @(posedge clk) begin
    m_ss_r <= 62'(l_sq_r[0]) + 62'(l_sq_r[1]) + 62'(l_sq_r[2]);
    for (int i = 0; i < 3; i++) m_side_r.mag[i] <= l_mag_r[i];
    m_side_r.sgn  <= l_s_r;
    m_side_r.zero <= l_zero_r;
    m_side_r.info <= l_info_r;
  end

  // ---------------- square root ----------------
  logic        sq_vld;
  logic [30:0] sq_root;
  sq_side_t    sq_side;

  dpsu_sqrt #(
    .VW (62),
    .SW ($bits(sq_side_t))
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (m_vld_r),
    .in_val    (m_ss_r),
    .in_side   (m_side_r),
    .out_valid (sq_vld),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // ---------------- stage N: division operands ----------------
  logic                  n_vld_r;
  logic [2:0][44:0]      n_num_r;
  logic [30:0]           n_den_r;
  dv_side_t              n_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) n_vld_r <= 1'b0;
    else n_vld_r <= sq_vld;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      n_num_r[i] <= {1'b0, sq_side.mag[i], 14'd0} + 45'(sq_root >> 1);
    end
    n_den_r       <= sq_root;
    n_side_r.sgn  <= sq_side.sgn;
    n_side_r.zero <= sq_side.zero;
    n_side_r.info <= sq_side.info;
  end

  logic             dv_vld;
  logic [2:0][14:0] dv_quot;
  dv_side_t         dv_side;

  dpsu_div #(
    .NW    (45),
    .DW    (31),
    .QW    (15),
    .LANES (3),
    .SW    ($bits(dv_side_t))
  ) u_ndiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (n_vld_r),
    .in_num    (n_num_r),
    .in_den    (n_den_r),
    .in_side   (n_side_r),
    .out_valid (dv_vld),
    .out_quot  (dv_quot),
    .out_side  (dv_side)
  );

  // ---------------- stage O: normal, radius operands ----------------
  logic [2:0][15:0] nrm;
  logic [14:0]      nz_mag, qf;
  logic [56:0]      rsum;

  always_comb begin
    if (dv_side.info.border) begin
      nrm    = '0;
      nz_mag = '0;
    end else if (dv_side.zero) begin
      nrm    = {16'(dpsu_pkg::N_ONE), 16'd0, 16'd0};
      nz_mag = dpsu_pkg::N_ONE;
    end else begin
      for (int i = 0; i < 3; i++) begin
        nrm[i] = dv_side.sgn[i] ? 16'(-{1'b0, dv_quot[i]}) : {1'b0, dv_quot[i]};
      end
      nz_mag = dv_quot[2];
    end
    qf   = (nz_mag > dpsu_pkg::NZ_FLOOR) ? nz_mag : dpsu_pkg::NZ_FLOOR;
    // round half up of num / (qf << 18) split as a shift then a divide by qf
    rsum = {1'b0, dv_side.info.num} + {25'd0, qf, 17'd0};
  end

  logic            o_vld_r;
  logic [0:0][37:0] o_np_r;
  logic [14:0]     o_qf_r;
  rd_side_t        o_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) o_vld_r <= 1'b0;
    else o_vld_r <= dv_vld;
  end

  always_ff @(posedge clk) begin
    o_np_r[0]    <= rsum[55:18];
    o_qf_r       <= qf;
    o_side_r.px  <= dv_side.info.px;
    o_side_r.py  <= dv_side.info.py;
    o_side_r.pz  <= dv_side.info.pz;
    o_side_r.col <= dv_side.info.col;
    o_side_r.nrm <= nrm;
  end

  logic             rd_vld;
  logic [0:0][25:0] rd_quot;
  rd_side_t         rd_side;

  dpsu_div #(
    .NW    (38),
    .DW    (15),
    .QW    (26),
    .LANES (1),
    .SW    ($bits(rd_side_t))
  ) u_rdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (o_vld_r),
    .in_num    (o_np_r),
    .in_den    (o_qf_r),
    .in_side   (o_side_r),
    .out_valid (rd_vld),
    .out_quot  (rd_quot),
    .out_side  (rd_side)
  );

  // ---------------- result transfer ----------------
  assign out_strobe       = rd_vld;
  assign out_point_x      = rd_side.px;
  assign out_point_y      = rd_side.py;
  assign out_point_z      = rd_side.pz;
  assign out_normal_x     = rd_side.nrm[0];
  assign out_normal_y     = rd_side.nrm[1];
  assign out_normal_z     = rd_side.nrm[2];
  assign out_splat_radius = {6'd0, rd_quot[0]};
  assign out_colour_red   = rd_side.col[23:16];
  assign out_colour_green = rd_side.col[15:8];
  assign out_colour_blue  = rd_side.col[7:0];

endmodule

/* hw/rtl/dpsu_sqrt.sv */
module dpsu_sqrt #(
  parameter int VW = 62,
  parameter int SW = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [VW-1:0]     in_val,
  input  logic [SW-1:0]     in_side,
  output logic              out_valid,
  output logic [VW/2-1:0]   out_root,
  output logic [SW-1:0]     out_side
);

  localparam int STEPS = VW / 2;

  logic          vld_r  [STEPS];
  logic [VW-1:0] rem_r  [STEPS];
  logic [VW-1:0] root_r [STEPS];
  logic [SW-1:0] side_r [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam logic [VW-1:0] BIT = VW'(1) << (VW - 2 - 2 * k);
    logic          vld_in;
    logic [VW-1:0] rem_in, root_in, rem_nxt, root_nxt, trial;
    logic [SW-1:0] side_in;

    if (k == 0) begin : g_first
      assign vld_in  = in_valid;
      assign rem_in  = in_val;
      assign root_in = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign side_in = side_r[k-1];
    end

    always_comb begin
      trial = root_in + BIT;
      if (rem_in >= trial) begin
        rem_nxt  = rem_in - trial;
        root_nxt = (root_in >> 1) + BIT;
      end else begin
        rem_nxt  = rem_in;
        root_nxt = root_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= rem_nxt;
      root_r[k] <= root_nxt;
      side_r[k] <= side_in;
    end
  end

  assign out_valid = vld_r[STEPS-1];
  assign out_root  = root_r[STEPS-1][VW/2-1:0];
  assign out_side  = side_r[STEPS-1];

endmodule

/* hw/rtl/dpsu_div.sv */
module dpsu_div #(
  parameter int NW    = 45,
  parameter int DW    = 31,
  parameter int QW    = 15,
  parameter int LANES = 3,
  parameter int SW    = 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [LANES-1:0][NW-1:0]    in_num,
  input  logic [DW-1:0]               in_den,
  input  logic [SW-1:0]               in_side,
  output logic                        out_valid,
  output logic [LANES-1:0][QW-1:0]    out_quot,
  output logic [SW-1:0]               out_side
);

  // restoring division, one quotient bit per stage; quotient must fit QW bits
  logic                     vld_r  [QW];
  logic [LANES-1:0][DW-1:0] rem_r  [QW];
  logic [LANES-1:0][QW-1:0] quo_r  [QW];
  logic [DW-1:0]            den_r  [QW];
  logic [SW-1:0]            side_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic                     vld_in;
    logic [LANES-1:0][DW-1:0] rem_in, rem_nxt;
    logic [LANES-1:0][QW-1:0] quo_in, quo_nxt;
    logic [LANES-1:0][DW:0]   trial;
    logic [DW-1:0]            den_in;
    logic [SW-1:0]            side_in;

    if (k == 0) begin : g_first
      always_comb begin
        vld_in  = in_valid;
        den_in  = in_den;
        side_in = in_side;
        for (int l = 0; l < LANES; l++) begin
          rem_in[l] = DW'(in_num[l][NW-1:QW]);
          quo_in[l] = in_num[l][QW-1:0];
        end
      end
    end else begin : g_next
      assign vld_in  = vld_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign quo_in  = quo_r[k-1];
      assign den_in  = den_r[k-1];
      assign side_in = side_r[k-1];
    end

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        trial[l] = {rem_in[l], quo_in[l][QW-1]};
        if (trial[l] >= {1'b0, den_in}) begin
          rem_nxt[l] = DW'(trial[l] - {1'b0, den_in});
          quo_nxt[l] = {quo_in[l][QW-2:0], 1'b1};
        end else begin
          rem_nxt[l] = trial[l][DW-1:0];
          quo_nxt[l] = {quo_in[l][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= rem_nxt;
      quo_r[k]  <= quo_nxt;
      den_r[k]  <= den_in;
      side_r[k] <= side_in;
    end
  end

  assign out_valid = vld_r[QW-1];
  assign out_quot  = quo_r[QW-1];
  assign out_side  = side_r[QW-1];

endmodule
